### src/apa_pkg.sv
// shared types and constants for the four-quadrant arctangent block
package apa_pkg;

    // vector and ratio widths
    localparam int COMP_W  = 16;
    localparam int MAG_W   = COMP_W + 1;
    localparam int RATIO_W = 17;
    localparam int ANGLE_W = 16;

    // restoring divider: one quotient bit per stage
    localparam int DIV_STEPS = RATIO_W;

    // queue between front and back, depth must be a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // polynomial coefficients in Q16
    localparam logic [11:0] COEF_C7 = 12'd3047;
    localparam logic [13:0] COEF_C5 = 14'd10441;
    localparam logic [14:0] COEF_C3 = 15'd21471;

    // angle constants in Q16
    localparam logic [17:0] PI_Q16      = 18'd205887;
    localparam logic [17:0] HALF_PI_Q16 = 18'd102944;

    // rounding offsets
    localparam int          RND_SHIFT = 16;
    localparam logic [15:0] RND_HALF  = 16'd32768;
    localparam logic [17:0] RND_Q13   = 18'd4;

    // output range in Q3.13
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sd25736;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -16'sd25736;

    // octant and quadrant flags carried alongside each item
    typedef struct packed {
        logic swap;   // vertical magnitude exceeds horizontal
        logic hneg;   // horizontal component negative
        logic vneg;   // vertical component negative
        logic zero;   // zero vector
    } apa_oct_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [MAG_W-1:0] mag_max;
        logic [MAG_W-1:0] mag_min;
        apa_oct_t         oct;
    } apa_cls_t;

endpackage

### src/apa_front.sv
// front stage: accepts vectors, forms magnitudes and octant flags
module apa_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [apa_pkg::COMP_W-1:0] vec_horizontal,
    input  logic signed [apa_pkg::COMP_W-1:0] vec_vertical,
    output logic                            cls_valid,
    output apa_pkg::apa_cls_t               cls,
    input  logic                            cls_full
);

    logic                          front_valid_reg;
    logic                          front_valid_next;
    apa_pkg::apa_cls_t             cls_reg;
    apa_pkg::apa_cls_t             cls_next;
    logic signed [apa_pkg::MAG_W-1:0] h_ext;
    logic signed [apa_pkg::MAG_W-1:0] v_ext;
    logic [apa_pkg::MAG_W-1:0]     h_mag;
    logic [apa_pkg::MAG_W-1:0]     v_mag;
    logic                          take;
    logic                          push;

    // handshake toward the input and the queue
    assign in_stall  = front_valid_reg && cls_full;
    assign take      = in_valid && !in_stall;
    assign push      = front_valid_reg && !cls_full;
    assign cls_valid = front_valid_reg;
    assign cls       = cls_reg;

    // magnitudes and classification
    always_comb
    begin
        h_ext = {vec_horizontal[apa_pkg::COMP_W-1], vec_horizontal};
        v_ext = {vec_vertical[apa_pkg::COMP_W-1], vec_vertical};
        h_mag = vec_horizontal[apa_pkg::COMP_W-1] ? apa_pkg::MAG_W'(-h_ext)
                                                  : apa_pkg::MAG_W'(h_ext);
        v_mag = vec_vertical[apa_pkg::COMP_W-1] ? apa_pkg::MAG_W'(-v_ext)
                                                : apa_pkg::MAG_W'(v_ext);
        cls_next.oct.swap = v_mag > h_mag;
        cls_next.oct.hneg = vec_horizontal[apa_pkg::COMP_W-1];
        cls_next.oct.vneg = vec_vertical[apa_pkg::COMP_W-1];
        cls_next.mag_max  = (h_mag > v_mag) ? h_mag : v_mag;
        cls_next.mag_min  = (h_mag > v_mag) ? v_mag : h_mag;
        cls_next.oct.zero = (h_mag == '0) && (v_mag == '0);
    end

    // valid flag of the front register
    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (take)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cls_reg <= cls_next;
        end
    end

endmodule

### src/apa_fifo.sv
// short queue of classified items between front and back
module apa_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  apa_pkg::apa_cls_t push_data,
    output logic              full,
    input  logic              pop,
    output apa_pkg::apa_cls_t head,
    output logic              empty
);

    apa_pkg::apa_cls_t                entries [apa_pkg::FIFO_DEPTH];
    logic [apa_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [apa_pkg::FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [apa_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [apa_pkg::FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [apa_pkg::FIFO_CNT_W-1:0]   cnt_reg;
    logic [apa_pkg::FIFO_CNT_W-1:0]   cnt_next;
    logic                             do_push;
    logic                             do_pop;

    // status
    assign full    = cnt_reg == apa_pkg::FIFO_CNT_W'(apa_pkg::FIFO_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    // occupancy never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= apa_pkg::FIFO_CNT_W'(apa_pkg::FIFO_DEPTH))
        else $error("queue count beyond depth");

    // the back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

### src/apa_div.sv
// pipelined restoring divider: ratio = floor(min * 2^16 / max), one bit per stage
module apa_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              load_valid,
    input  apa_pkg::apa_cls_t                 load,
    output logic                              ratio_valid,
    output logic [apa_pkg::RATIO_W-1:0]       ratio,
    output apa_pkg::apa_oct_t                 ratio_oct
);

    logic [apa_pkg::DIV_STEPS-1:0]  vld_reg;
    logic [apa_pkg::MAG_W-1:0]      rem_reg  [apa_pkg::DIV_STEPS];
    logic [apa_pkg::RATIO_W-1:0]    quo_reg  [apa_pkg::DIV_STEPS];
    logic [apa_pkg::MAG_W-1:0]      div_reg  [apa_pkg::DIV_STEPS];
    apa_pkg::apa_oct_t              oct_reg  [apa_pkg::DIV_STEPS];
    logic [apa_pkg::MAG_W-1:0]      rem_next [apa_pkg::DIV_STEPS];
    logic [apa_pkg::RATIO_W-1:0]    quo_next [apa_pkg::DIV_STEPS];

    // one compare and subtract per stage
    for (genvar k = 0; k < apa_pkg::DIV_STEPS; k++)
    begin : g_step
        logic [apa_pkg::MAG_W-1:0]   rem_in;
        logic [apa_pkg::RATIO_W-1:0] quo_in;
        logic [apa_pkg::MAG_W-1:0]   dvs;
        logic [apa_pkg::MAG_W-1:0]   trial;
        apa_pkg::apa_oct_t           oct_in;
        logic                        bit_q;

        if (k == 0)
        begin : g_first
            // top quotient bit: the minimum against the maximum itself
            assign rem_in = load.mag_min;
            assign quo_in = '0;
            assign dvs    = load.mag_max;
            assign trial  = rem_in;
            assign oct_in = load.oct;
        end
        else
        begin : g_rest
            // remainder stays below the divisor, so doubling fits
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign dvs    = div_reg[k-1];
            assign trial  = {rem_in[apa_pkg::MAG_W-2:0], 1'b0};
            assign oct_in = oct_reg[k-1];
        end

        assign bit_q       = trial >= dvs;
        assign rem_next[k] = bit_q ? trial - dvs : trial;
        assign quo_next[k] = {quo_in[apa_pkg::RATIO_W-2:0], bit_q};

        // stage payload
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                div_reg[k] <= dvs;
                oct_reg[k] <= oct_in;
            end
        end
    end

    // valid chain through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[apa_pkg::DIV_STEPS-2:0], load_valid};
        end
    end

    // a zero vector gives a zero ratio
    assign ratio_valid = vld_reg[apa_pkg::DIV_STEPS-1];
    assign ratio_oct   = oct_reg[apa_pkg::DIV_STEPS-1];
    assign ratio       = ratio_oct.zero ? '0 : quo_reg[apa_pkg::DIV_STEPS-1];

endmodule

### src/apa_back.sv
// back part: divider, polynomial pipeline, octant reflection, result register
module apa_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 head_empty,
    input  apa_pkg::apa_cls_t                    head,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [apa_pkg::ANGLE_W-1:0]   angle
);

    logic                                adv;
    logic                                t_valid;
    logic [apa_pkg::RATIO_W-1:0]         t_val;
    apa_pkg::apa_oct_t                   t_oct;

    // pipeline registers
    logic                                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic                                out_valid_reg;
    apa_pkg::apa_oct_t                   f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, f6_reg, f7_reg;
    logic                                vneg_o_reg;
    logic [apa_pkg::RATIO_W-1:0]         t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [apa_pkg::RATIO_W-1:0]         s2_reg, s3_reg;
    logic [32:0]                         tt_reg;
    logic [28:0]                         c7s_reg;
    logic [30:0]                         p1s_reg;
    logic [31:0]                         m2s_reg;
    logic [32:0]                         m3t_reg;
    logic [apa_pkg::RATIO_W-1:0]         r_reg;
    logic [17:0]                         mag_reg;
    logic signed [apa_pkg::ANGLE_W-1:0]  angle_reg;

    // next values
    logic [32:0]                         tt_next;
    logic [32:0]                         s_sum;
    logic [apa_pkg::RATIO_W-1:0]         s_next;
    logic [28:0]                         c7s_next;
    logic [28:0]                         c7s_sum;
    logic [13:0]                         p1;
    logic [30:0]                         p1s_next;
    logic [30:0]                         p1s_sum;
    logic [14:0]                         m2;
    logic [31:0]                         m2s_next;
    logic [31:0]                         m2s_sum;
    logic [15:0]                         m3;
    logic [32:0]                         m3t_next;
    logic [32:0]                         m3t_sum;
    logic [apa_pkg::RATIO_W-1:0]         r_next;
    logic [17:0]                         r_oct;
    logic [17:0]                         mag_next;
    logic [17:0]                         mag_rnd;
    logic [15:0]                         q_mag;
    logic signed [apa_pkg::ANGLE_W-1:0]  angle_next;

    // whole back advances when the result register is free or being taken
    assign adv       = !out_valid_reg || !out_stall;
    assign pop       = adv && !head_empty;
    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;

    apa_div u_div
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .load_valid  (!head_empty),
        .load        (head),
        .ratio_valid (t_valid),
        .ratio       (t_val),
        .ratio_oct   (t_oct)
    );

    // polynomial datapath, one multiply per stage, all products rounded in Q16
    always_comb
    begin
        // t squared
        tt_next  = 33'(t_val) * 33'(t_val);
        // s = round(t*t), then c7 * s
        s_sum    = tt_reg + 33'(apa_pkg::RND_HALF);
        s_next   = s_sum[32:16];
        c7s_next = 29'(apa_pkg::COEF_C7) * 29'(s_next);
        // p1 = c5 - round(c7 * s), then p1 * s
        c7s_sum  = c7s_reg + 29'(apa_pkg::RND_HALF);
        p1       = apa_pkg::COEF_C5 - 14'(c7s_sum[28:16]);
        p1s_next = 31'(p1) * 31'(s2_reg);
        // magnitude of p2 = c3 - round(p1 * s), then times s
        p1s_sum  = p1s_reg + 31'(apa_pkg::RND_HALF);
        m2       = apa_pkg::COEF_C3 - 15'(p1s_sum[30:16]);
        m2s_next = 32'(m2) * 32'(s3_reg);
        // magnitude of p3, then times t
        m2s_sum  = m2s_reg + 32'(apa_pkg::RND_HALF);
        m3       = m2s_sum[31:16];
        m3t_next = 33'(m3) * 33'(t4_reg);
        // first-octant angle r = t - round(m3 * t)
        m3t_sum  = m3t_reg + 33'(apa_pkg::RND_HALF);
        r_next   = t5_reg - m3t_sum[32:16];
    end

    // octant and quadrant reflection, then round to Q3.13 with sign
    always_comb
    begin
        r_oct      = f6_reg.swap ? apa_pkg::HALF_PI_Q16 - 18'(r_reg) : 18'(r_reg);
        mag_next   = f6_reg.hneg ? apa_pkg::PI_Q16 - r_oct : r_oct;
        mag_rnd    = mag_reg + apa_pkg::RND_Q13;
        q_mag      = {1'b0, mag_rnd[17:3]};
        angle_next = f7_reg.vneg ? $signed(16'(-q_mag)) : $signed(q_mag);
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= t_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            out_valid_reg <= v7_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tt_reg     <= tt_next;
            t1_reg     <= t_val;
            f1_reg     <= t_oct;
            c7s_reg    <= c7s_next;
            s2_reg     <= s_next;
            t2_reg     <= t1_reg;
            f2_reg     <= f1_reg;
            p1s_reg    <= p1s_next;
            s3_reg     <= s2_reg;
            t3_reg     <= t2_reg;
            f3_reg     <= f2_reg;
            m2s_reg    <= m2s_next;
            t4_reg     <= t3_reg;
            f4_reg     <= f3_reg;
            m3t_reg    <= m3t_next;
            t5_reg     <= t4_reg;
            f5_reg     <= f4_reg;
            r_reg      <= r_next;
            f6_reg     <= f5_reg;
            mag_reg    <= mag_next;
            f7_reg     <= f6_reg;
            angle_reg  <= angle_next;
            vneg_o_reg <= f7_reg.vneg;
        end
    end

    // result always within minus pi to pi
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (angle_reg >= apa_pkg::ANGLE_MIN && angle_reg <= apa_pkg::ANGLE_MAX))
        else $error("angle out of range");

    // upper half plane gives a non-negative angle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !vneg_o_reg) |-> !angle_reg[apa_pkg::ANGLE_W-1])
        else $error("sign of angle does not follow vertical component");

    // lower half plane gives a non-positive angle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && vneg_o_reg) |-> (angle_reg[apa_pkg::ANGLE_W-1] || angle_reg == '0))
        else $error("negative vertical gave positive angle");

endmodule

### src/atan2_polynomial_approx.sv
// top level of the four-quadrant polynomial arctangent
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, vec_horizontal, vec_vertical | in (stall out)
//  output  | out_valid, out_stall, angle               | out (stall in)
//
//  one item per cycle sustained when nothing stalls
//  path: front register, queue, 17-stage restoring divider, 8-stage polynomial pipeline
//  rst_n clears all valid flags and the queue pointers; payload registers are not reset
//  an output stall while out_valid is high freezes the back part; the 4-entry queue and
//  front register keep accepting items until they fill, then in_stall rises
module atan2_polynomial_approx
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [apa_pkg::COMP_W-1:0]    vec_horizontal,
    input  logic signed [apa_pkg::COMP_W-1:0]    vec_vertical,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [apa_pkg::ANGLE_W-1:0]   angle
);

    logic              cls_valid;
    apa_pkg::apa_cls_t cls;
    logic              q_full;
    logic              q_pop;
    apa_pkg::apa_cls_t q_head;
    logic              q_empty;

    // classify incoming vectors
    apa_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .vec_horizontal (vec_horizontal),
        .vec_vertical   (vec_vertical),
        .cls_valid      (cls_valid),
        .cls            (cls),
        .cls_full       (q_full)
    );

    // decoupling queue
    apa_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cls_valid),
        .push_data (cls),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // divide, evaluate and reflect
    apa_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_empty (q_empty),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .angle      (angle)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the four-quadrant polynomial arctangent block
module tb_top;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 4;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 100;

    // fixed-point constants of the arctangent, all in Q16
    localparam longint RATIO_ONE   = 65536;
    localparam longint ATAN_K7     = 3047;
    localparam longint ATAN_K5     = 10441;
    localparam longint ATAN_K3     = 21471;
    localparam longint PI_FIX      = 205887;
    localparam longint HALF_PI_FIX = 102944;

    localparam logic signed [apa_pkg::COMP_W-1:0] COMP_MIN = 16'sh8000;
    localparam logic signed [apa_pkg::COMP_W-1:0] COMP_MAX = 16'sh7FFF;

    logic                                clk            = 1'b0;
    logic                                rst_n          = 1'b0;
    logic                                in_valid       = 1'b0;
    logic                                out_stall      = 1'b0;
    logic signed [apa_pkg::COMP_W-1:0]   vec_horizontal = '0;
    logic signed [apa_pkg::COMP_W-1:0]   vec_vertical   = '0;
    wire                                 in_stall;
    wire                                 out_valid;
    wire signed [apa_pkg::ANGLE_W-1:0]   angle;

    logic signed [apa_pkg::ANGLE_W-1:0]  pending_angles[$];
    int                         vecs_accepted  = 0;
    int                         angles_checked = 0;
    int                         error_count    = 0;
    int                         quiet_cycles   = 0;
    int                         send_idle_pct  = 0;
    int                         recv_idle_pct  = 0;
    int                         hold_requests  = 0;
    int                         holds_done     = 0;

    atan2_polynomial_approx dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .vec_horizontal (vec_horizontal),
        .vec_vertical   (vec_vertical),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle          (angle)
    );

    always #CLK_HALF clk = ~clk;

    // divide by 2^n, rounded to nearest with ties away from zero
    function automatic longint round_away(longint x, int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (x >= 0)
            return (x + half) >>> n;
        return -((-x + half) >>> n);
    endfunction

    function automatic longint q16_product(longint a, longint b);
        return round_away(a * b, 16);
    endfunction

    // expected angle in Q3.13 for one vector
    function automatic logic signed [apa_pkg::ANGLE_W-1:0] predict_angle(
        logic signed [apa_pkg::COMP_W-1:0] h,
        logic signed [apa_pkg::COMP_W-1:0] v
    );
        longint ha;
        longint va;
        longint big;
        longint lesser;
        longint ratio;
        longint sq;
        longint acc;
        longint rad;
        ha     = (h < 0) ? -longint'(h) : longint'(h);
        va     = (v < 0) ? -longint'(v) : longint'(v);
        big    = (ha > va) ? ha : va;
        lesser = (ha > va) ? va : ha;
        // zero vector gives a zero ratio
        ratio  = (big != 0) ? (lesser * RATIO_ONE) / big : 0;
        sq     = q16_product(ratio, ratio);
        acc    = q16_product(-ATAN_K7, sq) + ATAN_K5;
        acc    = q16_product(acc, sq) - ATAN_K3;
        acc    = q16_product(acc, sq);
        acc    = q16_product(acc, ratio);
        rad    = acc + ratio;
        // octant and quadrant folding
        if (va > ha)
            rad = HALF_PI_FIX - rad;
        if (h < 0)
            rad = PI_FIX - rad;
        if (v < 0)
            rad = -rad;
        rad = round_away(rad, 3);
        return rad[apa_pkg::ANGLE_W-1:0];
    endfunction

    // record the expected angle of every accepted vector
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            pending_angles.push_back(predict_angle(vec_horizontal, vec_vertical));
            vecs_accepted++;
        end
    end

    // compare each delivered angle with the oldest expectation
    always @(posedge clk)
    begin
        logic signed [apa_pkg::ANGLE_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_angles.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: angle expected none, actual %0d", $time, angle);
            end
            else
            begin
                want = pending_angles.pop_front();
                angles_checked++;
                if (angle !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: angle expected %0d, actual %0d", $time, want, angle);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver: random stalls, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_done < hold_requests)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                holds_done++;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // offer one vector, with random gaps ahead of it, until accepted
    task automatic send_vector(input logic signed [apa_pkg::COMP_W-1:0] h,
                               input logic signed [apa_pkg::COMP_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        vec_horizontal <= h;
        vec_vertical   <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop sending until every expected angle has come back
    task automatic drain_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_angles.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [apa_pkg::COMP_W-1:0] pick_extreme();
        case ($urandom_range(5))
            0:       return COMP_MIN;
            1:       return COMP_MIN + 16'sd1;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            default: return COMP_MAX;
        endcase
    endfunction

    // zero vector, axes, diagonals, octant edges, most negative components
    task automatic test_directed;
        send_vector(16'sd0, 16'sd0);
        send_vector(COMP_MAX, 16'sd0);
        send_vector(COMP_MIN, 16'sd0);
        send_vector(-16'sd1, 16'sd0);
        send_vector(16'sd0, COMP_MAX);
        send_vector(16'sd0, COMP_MIN);
        send_vector(16'sd0, 16'sd1);
        send_vector(16'sd0, -16'sd1);
        send_vector(16'sd1, 16'sd1);
        send_vector(-16'sd1, 16'sd1);
        send_vector(-16'sd1, -16'sd1);
        send_vector(16'sd1, -16'sd1);
        send_vector(COMP_MIN, COMP_MIN);
        send_vector(COMP_MAX, COMP_MIN);
        send_vector(COMP_MIN, COMP_MAX);
        send_vector(16'sd100, 16'sd99);
        send_vector(16'sd99, 16'sd100);
        send_vector(-16'sd99, -16'sd100);
        send_vector(16'sd12345, -16'sd6789);
        send_vector(-16'sd32767, COMP_MAX);
        drain_results;
    endtask

    // random vectors mixed with small ones, diagonals, near-diagonals, axes and extremes
    task automatic test_random(input int count);
        int                                mag_a;
        int                                mag_b;
        logic signed [apa_pkg::COMP_W-1:0] h;
        logic signed [apa_pkg::COMP_W-1:0] v;
        repeat (count)
        begin
            case ($urandom_range(9))
                4:
                begin
                    h = apa_pkg::COMP_W'(int'($urandom_range(16)) - 8);
                    v = apa_pkg::COMP_W'(int'($urandom_range(16)) - 8);
                end
                5:
                begin
                    mag_a = int'($urandom_range(32767));
                    h = $urandom_range(1) ? apa_pkg::COMP_W'(-mag_a)
                                          : apa_pkg::COMP_W'(mag_a);
                    v = $urandom_range(1) ? apa_pkg::COMP_W'(-mag_a)
                                          : apa_pkg::COMP_W'(mag_a);
                end
                6:
                begin
                    // one step off the diagonal, either side
                    mag_a = int'($urandom_range(32766, 1));
                    mag_b = $urandom_range(1) ? mag_a + 1 : mag_a - 1;
                    h = $urandom_range(1) ? apa_pkg::COMP_W'(-mag_a)
                                          : apa_pkg::COMP_W'(mag_a);
                    v = $urandom_range(1) ? apa_pkg::COMP_W'(-mag_b)
                                          : apa_pkg::COMP_W'(mag_b);
                end
                7:
                begin
                    if ($urandom_range(1))
                    begin
                        h = apa_pkg::COMP_W'($urandom);
                        v = 16'sd0;
                    end
                    else
                    begin
                        h = 16'sd0;
                        v = apa_pkg::COMP_W'($urandom);
                    end
                end
                8:
                begin
                    h = pick_extreme();
                    v = pick_extreme();
                end
                9:
                begin
                    h = $urandom_range(1) ? COMP_MIN : apa_pkg::COMP_W'($urandom);
                    v = (h == COMP_MIN) ? apa_pkg::COMP_W'($urandom) : COMP_MIN;
                end
                default:
                begin
                    h = apa_pkg::COMP_W'($urandom);
                    v = apa_pkg::COMP_W'($urandom);
                end
            endcase
            send_vector(h, v);
        end
        drain_results;
    endtask

    // long output hold-off while vectors keep coming, so the input stalls
    task automatic test_output_hold;
        hold_requests++;
        repeat (48)
            send_vector(apa_pkg::COMP_W'($urandom), apa_pkg::COMP_W'($urandom));
        drain_results;
    endtask

    initial
    begin
        send_idle_pct = 32;
        recv_idle_pct = 47;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed;
        test_random(360);
        send_idle_pct = 47;
        recv_idle_pct = 32;
        test_random(360);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(360);
        test_output_hold;

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d vectors accepted, %0d angles compared, %0d errors",
                 vecs_accepted, angles_checked, error_count);
        $display("covered axes, diagonals, octant edges, most negative inputs, idling, hold-off");
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
src/apa_pkg.sv
src/apa_front.sv
src/apa_fifo.sv
src/apa_div.sv
src/apa_back.sv
src/atan2_polynomial_approx.sv
sim/tb_top.sv
